/* sv/dod_pkg.sv */
`default_nettype none
package dod_pkg;

	localparam int CORDIC_STEPS_DEF = 24;
	localparam int CFG_IDX_W = 3;

	localparam logic signed [31:0] PI_Q      = 32'sd843314856;
	localparam logic signed [31:0] HALF_PI_Q = 32'sd421657428;
	localparam logic signed [31:0] TWO_PI_Q  = 32'sd1686629713;
	localparam logic signed [33:0] GAIN_Q30  = 34'sd652032874;

	// 2^51 over two pi, and two pi doubled for an exact product with a shift of one
	localparam logic [31:0] INV_TWO_PI_Q = 32'd1335088;
	localparam logic [31:0] TWO_PI_X2_Q  = 32'd3373259426;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DPC    = 3'd0,
		REG_DIR    = 3'd1,
		REG_HR     = 3'd2,
		REG_ROS    = 3'd3,
		REG_INVSEP = 3'd4
	} reg_idx_t;

	typedef logic signed [53:0] wide_t;

	typedef struct packed {
		logic signed [33:0] a;
		logic signed [33:0] b;
		logic [4:0]         sh;
		logic               neg;
	} mul_req_t;

	function automatic logic [31:0] atan_q28(input logic [4:0] k);
		case (k)
			5'd0: return 32'd210828714;
			5'd1: return 32'd124459457;
			5'd2: return 32'd65760959;
			5'd3: return 32'd33381290;
			5'd4: return 32'd16755422;
			5'd5: return 32'd8385879;
			5'd6: return 32'd4193963;
			5'd7: return 32'd2097109;
			5'd8: return 32'd1048571;
			5'd9: return 32'd524287;
			5'd10: return 32'd262144;
			5'd11: return 32'd131072;
			5'd12: return 32'd65536;
			5'd13: return 32'd32768;
			5'd14: return 32'd16384;
			5'd15: return 32'd8192;
			5'd16: return 32'd4096;
			5'd17: return 32'd2048;
			5'd18: return 32'd1024;
			5'd19: return 32'd512;
			5'd20: return 32'd256;
			5'd21: return 32'd128;
			5'd22: return 32'd64;
			5'd23: return 32'd32;
			5'd24: return 32'd16;
			5'd25: return 32'd8;
			5'd26: return 32'd4;
			5'd27: return 32'd2;
			5'd28: return 32'd1;
			default: return 32'd0;
		endcase
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
		if (v > 56'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -56'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage
`default_nettype wire

/* sv/dod_ifs.sv */
`default_nettype none
interface dod_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] left_count;
	logic signed [31:0] right_count;
	logic signed [31:0] left_rate;
	logic signed [31:0] right_rate;
	modport source(output valid, left_count, right_count, left_rate, right_rate, input ready);
	modport sink(input valid, left_count, right_count, left_rate, right_rate, output ready);
endinterface

interface dod_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_pos;
	logic signed [31:0] y_pos;
	logic signed [30:0] heading;
	logic signed [31:0] x_rate;
	logic signed [31:0] y_rate;
	logic signed [31:0] yaw_rate;
	logic signed [31:0] left_vel;
	logic signed [31:0] right_vel;
	logic signed [31:0] left_travel;
	logic signed [31:0] right_travel;
	modport source(output valid, x_pos, y_pos, heading, x_rate, y_rate, yaw_rate,
		left_vel, right_vel, left_travel, right_travel, input ready);
	modport sink(input valid, x_pos, y_pos, heading, x_rate, y_rate, yaw_rate,
		left_vel, right_vel, left_travel, right_travel, output ready);
endinterface

interface dod_cfg_if;
	import dod_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/dod_mulr.sv */
`default_nettype none
module dod_mulr (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  dod_pkg::mul_req_t req,
	output logic              done,
	output dod_pkg::wide_t    res
);
	import dod_pkg::*;

	logic        v_s1, v_s2, v_s3;
	logic [32:0] ma_s1;
	logic [31:0] mb_s1;
	logic        neg_s1, neg_s2;
	logic [4:0]  sh_s1, sh_s2;
	logic [64:0] p_s2;
	wide_t       res_s3;

	logic [33:0] abs_a, abs_b;
	logic [64:0] shq, shr;
	logic [53:0] q;

	assign abs_a = req.a[33] ? 34'(-req.a) : 34'(req.a);
	assign abs_b = req.b[33] ? 34'(-req.b) : 34'(req.b);
	assign shq   = p_s2 >> sh_s2;
	assign shr   = p_s2 >> (sh_s2 - 5'd1);
	assign q     = shq[53:0] + {53'd0, shr[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ma_s1  <= abs_a[32:0];
		mb_s1  <= abs_b[31:0];
		neg_s1 <= req.a[33] ^ req.b[33] ^ req.neg;
		sh_s1  <= req.sh;
		p_s2   <= 65'(ma_s1) * 65'(mb_s1);
		neg_s2 <= neg_s1;
		sh_s2  <= sh_s1;
		res_s3 <= neg_s2 ? -$signed(q) : $signed(q);
	end

	assign done = v_s3;
	assign res  = res_s3;
endmodule
`default_nettype wire

/* sv/dod_cordic.sv */
`default_nettype none
module dod_cordic #(
	parameter int STEPS = dod_pkg::CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [30:0] angle,
	output logic               done,
	output logic signed [33:0] cs,
	output logic signed [33:0] sn
);
	import dod_pkg::*;

	localparam int CW = $clog2(STEPS + 1);

	logic signed [33:0] x_q, y_q;
	logic signed [31:0] z_q;
	logic [CW-1:0]      cnt_q;
	logic               run_q, done_q, flip_q;

	logic [4:0]         k;
	logic signed [33:0] dx, dy;
	logic signed [31:0] at, z0, zf;
	logic               fl;

	assign k  = 5'(cnt_q);
	assign dx = y_q >>> k;
	assign dy = x_q >>> k;
	assign at = $signed(atan_q28(k));
	assign z0 = 32'(angle);

	always_comb begin
		zf = z0;
		fl = 1'b0;
		if (z0 > HALF_PI_Q) begin
			zf = z0 - PI_Q;
			fl = 1'b1;
		end else if (z0 < -HALF_PI_Q) begin
			zf = z0 + PI_Q;
			fl = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			x_q    <= '0;
			y_q    <= '0;
			z_q    <= '0;
			flip_q <= 1'b0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
			x_q    <= GAIN_Q30;
			y_q    <= '0;
			z_q    <= zf;
			flip_q <= fl;
		end else if (run_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(STEPS - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign cs   = flip_q ? -x_q : x_q;
	assign sn   = flip_q ? -y_q : y_q;
endmodule
`default_nettype wire

/* sv/diff_drive_odometry.sv */
// channel   dir  words
// sample    in   left_count, right_count, left_rate, right_rate
// result    out  pose, heading, body rates, wheel speeds and travels
// cfg       in   index, data
//
// one sample: 15 products through one shared three-stage multiplier,
// a heading wrap fix-up state, a state to finish the heading, a state to load the output
// the sine/cosine iteration runs alongside the first nine products
// sample.ready is high only while idle; cfg.ready is always high
// the output load waits while the previous word is still unaccepted
`default_nettype none
module diff_drive_odometry #(
	parameter int CORDIC_STEPS = dod_pkg::CORDIC_STEPS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dod_in_if.sink     sample,
	dod_out_if.source  result,
	dod_cfg_if.sink    cfg
);
	import dod_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_MUL   = 6'b000010,
		S_MWAIT = 6'b000100,
		S_WRAP  = 6'b001000,
		S_FIN   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	localparam logic [3:0] OP_DR = 4'd0, OP_DL = 4'd1, OP_V = 4'd2, OP_YAW = 4'd3;
	localparam logic [3:0] OP_LSPD = 4'd4, OP_RSPD = 4'd5, OP_LTRV = 4'd6, OP_RTRV = 4'd7;
	localparam logic [3:0] OP_DH = 4'd8, OP_NX = 4'd9, OP_NY = 4'd10, OP_XR = 4'd11;
	localparam logic [3:0] OP_YR = 4'd12, OP_WQ = 4'd13, OP_WP = 4'd14;

	state_t state_q;
	logic [3:0] op_q;

	logic [31:0] dpc_q, hr_q, ros_q, isep_q;
	logic        dir_q;

	logic signed [31:0] prevl_q, prevr_q, posex_q, posey_q;
	logic signed [30:0] poseh_q;
	logic signed [31:0] lc_q, rc_q, lr_q, rr_q;

	logic signed [31:0] dr_q, dl_q, v_q, yaw_q, lspd_q, rspd_q, ltrv_q, rtrv_q;
	logic signed [31:0] nx_q, ny_q, xr_q, yr_q;
	wide_t              dh_q;
	logic signed [55:0] m_q;
	logic [23:0]        wq_q;
	logic               hneg_q;
	logic signed [30:0] nh_q;

	logic               ovalid_q;
	logic signed [31:0] o_x_q, o_y_q, o_xr_q, o_yr_q, o_yaw_q;
	logic signed [31:0] o_ls_q, o_rs_q, o_lt_q, o_rt_q;
	logic signed [30:0] o_h_q;

	mul_req_t           req;
	logic               mstart, mdone;
	wide_t              mres;
	logic               cstart, cdone;
	logic signed [33:0] cs, sn;

	logic signed [31:0] dlt_l, dlt_r, sres, r0, r1;
	logic signed [55:0] hsum;
	logic [55:0]        hmag;

	assign cstart = sample.valid & sample.ready;
	assign mstart = (state_q == S_MUL) && !(op_q >= OP_NX && !cdone);
	assign dlt_l  = lc_q - prevl_q;
	assign dlt_r  = rc_q - prevr_q;
	assign sres   = sat32(56'(mres));
	assign hsum   = 56'(poseh_q) + 56'(dh_q);
	assign hmag   = hsum[55] ? 56'(-hsum) : 56'(hsum);
	assign r0     = hneg_q ? -$signed(m_q[31:0]) : $signed(m_q[31:0]);

	always_comb begin
		r1 = r0;
		if (r0 > PI_Q) begin
			r1 = r0 - TWO_PI_Q;
		end else if (r0 < -PI_Q - 32'sd1) begin
			r1 = r0 + TWO_PI_Q;
		end
	end

	always_comb begin
		req.a   = 34'(dlt_r);
		req.b   = $signed({2'b00, dpc_q});
		req.sh  = 5'd24;
		req.neg = 1'b0;
		case (op_q)
			OP_DR: begin
			end
			OP_DL: begin
				req.a   = 34'(dlt_l);
				req.neg = 1'b1;
			end
			OP_V: begin
				req.a  = 34'(rr_q) - 34'(lr_q);
				req.b  = $signed({2'b00, hr_q});
				req.sh = 5'd16;
			end
			OP_YAW: begin
				req.a  = 34'(lr_q) - 34'(rr_q);
				req.b  = $signed({2'b00, ros_q});
				req.sh = 5'd16;
			end
			OP_LSPD: req.a = 34'(lr_q);
			OP_RSPD: req.a = 34'(rr_q);
			OP_LTRV: req.a = 34'(lc_q);
			OP_RTRV: req.a = 34'(rc_q);
			OP_DH: begin
				req.a  = 34'(dr_q) - 34'(dl_q);
				req.b  = $signed({2'b00, isep_q});
				req.sh = 5'd12;
			end
			OP_NX: begin
				req.a  = 34'(dr_q) + 34'(dl_q);
				req.b  = cs;
				req.sh = 5'd31;
			end
			OP_NY: begin
				req.a  = 34'(dr_q) + 34'(dl_q);
				req.b  = sn;
				req.sh = 5'd31;
			end
			OP_XR: begin
				req.a  = 34'(v_q);
				req.b  = cs;
				req.sh = 5'd30;
			end
			OP_YR: begin
				req.a  = 34'(v_q);
				req.b  = sn;
				req.sh = 5'd30;
			end
			// quotient estimate of the heading magnitude over two pi
			OP_WQ: begin
				req.a  = {1'b0, hmag[52:20]};
				req.b  = $signed({2'b00, INV_TWO_PI_Q});
				req.sh = 5'd31;
			end
			OP_WP: begin
				req.a  = {10'd0, wq_q};
				req.b  = $signed({2'b00, TWO_PI_X2_Q});
				req.sh = 5'd1;
			end
			default: begin
			end
		endcase
	end

	dod_mulr u_mulr (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mstart),
		.req   (req),
		.done  (mdone),
		.res   (mres)
	);

	dod_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cstart),
		.angle (poseh_q),
		.done  (cdone),
		.cs    (cs),
		.sn    (sn)
	);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpc_q  <= '0;
			dir_q  <= 1'b0;
			hr_q   <= '0;
			ros_q  <= '0;
			isep_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DPC:    dpc_q  <= cfg.data;
				REG_DIR:    dir_q  <= cfg.data[0];
				REG_HR:     hr_q   <= cfg.data;
				REG_ROS:    ros_q  <= cfg.data;
				REG_INVSEP: isep_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == S_OUT && (!ovalid_q || result.ready)) begin
			ovalid_q <= 1'b1;
		end else if (result.valid && result.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= OP_DR;
			prevl_q  <= '0;
			prevr_q  <= '0;
			posex_q  <= '0;
			posey_q  <= '0;
			poseh_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (sample.valid) begin
						lc_q    <= sample.left_count;
						rc_q    <= sample.right_count;
						lr_q    <= sample.left_rate;
						rr_q    <= sample.right_rate;
						op_q    <= OP_DR;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (mstart) begin
						state_q <= S_MWAIT;
					end
				end
				S_MWAIT: begin
					if (mdone) begin
						case (op_q)
							OP_DR:   dr_q  <= sres;
							OP_DL:   dl_q  <= sres;
							OP_V:    v_q   <= sres;
							OP_YAW:  yaw_q <= sres;
							OP_LSPD: lspd_q <= dir_q ? sat32(-56'(sres)) : sres;
							OP_RSPD: rspd_q <= dir_q ? sat32(-56'(sres)) : sres;
							OP_LTRV: ltrv_q <= dir_q ? sat32(-56'(sres)) : sres;
							OP_RTRV: rtrv_q <= dir_q ? sat32(-56'(sres)) : sres;
							OP_DH:   dh_q  <= mres;
							OP_NX:   nx_q  <= sat32(56'(posex_q) + 56'(mres));
							OP_NY:   ny_q  <= sat32(56'(posey_q) + 56'(mres));
							OP_XR:   xr_q  <= sres;
							OP_YR:   yr_q  <= sres;
							OP_WQ:   wq_q  <= mres[23:0];
							OP_WP: begin
								hneg_q <= hsum[55];
								m_q    <= $signed(hmag) - 56'(mres);
							end
							default: begin
							end
						endcase
						if (op_q == OP_WP) begin
							state_q <= S_WRAP;
						end else begin
							op_q    <= op_q + 4'd1;
							state_q <= S_MUL;
						end
					end
				end
				// quotient estimate is off by at most one
				S_WRAP: begin
					if (m_q < 0) begin
						m_q <= m_q + 56'(TWO_PI_Q);
					end else if (m_q >= 56'(TWO_PI_Q)) begin
						m_q <= m_q - 56'(TWO_PI_Q);
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					nh_q    <= r1[30:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!ovalid_q || result.ready) begin
						o_x_q    <= nx_q;
						o_y_q    <= ny_q;
						o_h_q    <= nh_q;
						o_xr_q   <= xr_q;
						o_yr_q   <= yr_q;
						o_yaw_q  <= yaw_q;
						o_ls_q   <= lspd_q;
						o_rs_q   <= rspd_q;
						o_lt_q   <= ltrv_q;
						o_rt_q   <= rtrv_q;
						posex_q  <= nx_q;
						posey_q  <= ny_q;
						poseh_q  <= nh_q;
						prevl_q  <= lc_q;
						prevr_q  <= rc_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sample.ready        = (state_q == S_IDLE);
	assign cfg.ready           = 1'b1;
	assign result.valid        = ovalid_q;
	assign result.x_pos        = o_x_q;
	assign result.y_pos        = o_y_q;
	assign result.heading      = o_h_q;
	assign result.x_rate       = o_xr_q;
	assign result.y_rate       = o_yr_q;
	assign result.yaw_rate     = o_yaw_q;
	assign result.left_vel     = o_ls_q;
	assign result.right_vel    = o_rs_q;
	assign result.left_travel  = o_lt_q;
	assign result.right_travel = o_rt_q;
endmodule
`default_nettype wire

/* tb/tb_diff_drive_odometry.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_diff_drive_odometry;
	import dod_pkg::*;

	typedef struct packed {
		logic signed [31:0] lc;
		logic signed [31:0] rc;
		logic signed [31:0] lr;
		logic signed [31:0] rr;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] x_pos;
		logic signed [31:0] y_pos;
		logic signed [30:0] heading;
		logic signed [31:0] x_rate;
		logic signed [31:0] y_rate;
		logic signed [31:0] yaw_rate;
		logic signed [31:0] left_vel;
		logic signed [31:0] right_vel;
		logic signed [31:0] left_travel;
		logic signed [31:0] right_travel;
	} pose_word_t;

	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dod_in_if  sample();
	dod_out_if result();
	dod_cfg_if cfg();

	diff_drive_odometry dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample.sink),
		.result(result.source),
		.cfg(cfg.sink)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// odometry predictor state
	logic [31:0] k_dpc, k_hr, k_ros, k_invsep;
	logic        k_neg;
	logic [31:0] last_lc, last_rc;
	longint      px, py, ph;

	sample_t    pending_samples[$];
	pose_word_t expected_poses[$];
	int         errors = 0;
	bit         steady = 0;
	bit         hold_off = 0;
	bit         in_fire = 0;
	int         quiet = 0;

	function automatic longint sx32(input logic [31:0] v);
		return longint'(signed'(v));
	endfunction

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint fl_shift(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint round_mul(input longint a, input longint b, input int sh);
		bit neg;
		logic [63:0] ma, mb, p, q;
		neg = (a < 0) != (b < 0);
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		p = ma * mb;
		q = (p >> sh) + ((p >> (sh - 1)) & 64'd1);
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint angle_trig(input longint ang, output longint s);
		longint x, y, z, dx, dy;
		longint atn[29];
		bit flip;
		atn = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
			2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
			4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
		x = 652032874;
		y = 0;
		z = ang;
		flip = 0;
		if (z > 421657428) begin
			z -= 843314856;
			flip = 1;
		end else if (z < -421657428) begin
			z += 843314856;
			flip = 1;
		end
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			dx = fl_shift(y, i);
			dy = fl_shift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= (i < 29 ? atn[i] : 0);
			end else begin
				x += dx; y -= dy; z += (i < 29 ? atn[i] : 0);
			end
		end
		if (flip) begin
			x = -x; y = -y;
		end
		s = y;
		return x;
	endfunction

	function automatic longint wrap_angle(input longint h);
		longint r;
		r = h % 64'sd1686629713;
		if (r > 843314856) r -= 1686629713;
		else if (r < -843314857) r += 1686629713;
		return r;
	endfunction

	function automatic longint steer(input longint v);
		return clip32(k_neg ? -v : v);
	endfunction

	function automatic pose_word_t advance_pose(input sample_t s);
		pose_word_t o;
		longint cs, sn, dl, dr, v, nx, ny, nh, lr, rr, dpc;
		logic [31:0] dlc, drc;
		dpc = longint'(k_dpc);
		lr = sx32(s.lr);
		rr = sx32(s.rr);
		cs = angle_trig(ph, sn);
		drc = s.rc - last_rc;
		dlc = s.lc - last_lc;
		dr = clip32(round_mul(sx32(drc), dpc, 24));
		dl = clip32(-round_mul(sx32(dlc), dpc, 24));
		nx = clip32(px + round_mul(dr + dl, cs, 31));
		ny = clip32(py + round_mul(dr + dl, sn, 31));
		nh = wrap_angle(ph + round_mul(dr - dl, longint'(k_invsep), 12));
		v = clip32(round_mul(rr - lr, longint'(k_hr), 16));
		o.x_pos = nx[31:0];
		o.y_pos = ny[31:0];
		o.heading = nh[30:0];
		o.x_rate = clip32(round_mul(v, cs, 30));
		o.y_rate = clip32(round_mul(v, sn, 30));
		o.yaw_rate = clip32(round_mul(lr - rr, longint'(k_ros), 16));
		o.left_vel = steer(clip32(round_mul(lr, dpc, 24)));
		o.right_vel = steer(clip32(round_mul(rr, dpc, 24)));
		o.left_travel = steer(clip32(round_mul(sx32(s.lc), dpc, 24)));
		o.right_travel = steer(clip32(round_mul(sx32(s.rc), dpc, 24)));
		px = nx; py = ny; ph = nh;
		last_lc = s.lc; last_rc = s.rc;
		return o;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h want %h", what, got, want);
	endtask

	// input handshake seen at the rising edge
	always @(posedge clk) begin
		in_fire <= arst_n && sample.valid && sample.ready;
	end

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			sample.valid <= 1'b0;
		end else begin
			if (in_fire) begin
				expected_poses.push_back(advance_pose(pending_samples.pop_front()));
			end
			if (!sample.valid || in_fire) begin
				if (pending_samples.size() > 0 && (steady || $urandom_range(99) >= 9)) begin
					sample.valid <= 1'b1;
					{sample.left_count, sample.right_count, sample.left_rate,
						sample.right_rate} <= pending_samples[0];
				end else begin
					sample.valid <= 1'b0;
				end
			end
		end
	end

	// monitor side ready
	always @(negedge clk) begin
		if (!arst_n) result.ready <= 1'b0;
		else result.ready <= !hold_off && (steady || $urandom_range(99) >= 9);
	end

	always @(posedge clk) begin
		pose_word_t e;
		if (arst_n && result.valid && result.ready) begin
			if (expected_poses.size() == 0) begin
				report("unexpected word", result.x_pos, 32'd0);
			end else begin
				e = expected_poses.pop_front();
				if (result.x_pos !== e.x_pos) report("x_pos", result.x_pos, e.x_pos);
				if (result.y_pos !== e.y_pos) report("y_pos", result.y_pos, e.y_pos);
				if (result.heading !== e.heading)
					report("heading", 32'(result.heading), 32'(e.heading));
				if (result.x_rate !== e.x_rate) report("x_rate", result.x_rate, e.x_rate);
				if (result.y_rate !== e.y_rate) report("y_rate", result.y_rate, e.y_rate);
				if (result.yaw_rate !== e.yaw_rate)
					report("yaw_rate", result.yaw_rate, e.yaw_rate);
				if (result.left_vel !== e.left_vel)
					report("left_vel", result.left_vel, e.left_vel);
				if (result.right_vel !== e.right_vel)
					report("right_vel", result.right_vel, e.right_vel);
				if (result.left_travel !== e.left_travel)
					report("left_travel", result.left_travel, e.left_travel);
				if (result.right_travel !== e.right_travel)
					report("right_travel", result.right_travel, e.right_travel);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (result.valid && result.ready)
			|| (cfg.valid && cfg.ready)) begin
			quiet <= 0;
		end else if (quiet >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] d);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= d;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		case (idx)
			REG_DPC: k_dpc = d;
			REG_DIR: k_neg = d[0];
			REG_HR: k_hr = d;
			REG_ROS: k_ros = d;
			REG_INVSEP: k_invsep = d;
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic settle();
		while (pending_samples.size() > 0 || sample.valid || expected_poses.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic setup(input logic [31:0] dpc, input logic neg, input logic [31:0] hr,
		input logic [31:0] ros, input logic [31:0] inv);
		write_reg(REG_DPC, dpc);
		write_reg(REG_DIR, {31'd0, neg});
		write_reg(REG_HR, hr);
		write_reg(REG_ROS, ros);
		write_reg(REG_INVSEP, inv);
	endtask

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'(signed'($urandom_range(8192)) - 4096);
			2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'(signed'($urandom_range(1 << 20)) - (1 << 19));
		endcase
	endfunction

	task automatic drive_phase(input int n);
		sample_t s;
		logic [31:0] lc, rc;
		lc = last_lc;
		rc = last_rc;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 80) begin
				lc += 32'(signed'($urandom_range(20000)) - 10000);
				rc += 32'(signed'($urandom_range(20000)) - 10000);
				s = {lc, rc, 32'(signed'($urandom_range(200000)) - 100000),
					32'(signed'($urandom_range(200000)) - 100000)};
			end else begin
				s = {rnd_word(), rnd_word(), rnd_word(), rnd_word()};
				lc = s.lc;
				rc = s.rc;
			end
			pending_samples.push_back(s);
		end
	endtask

	initial begin
		k_dpc = 0; k_neg = 0; k_hr = 0; k_ros = 0; k_invsep = 0;
		last_lc = 0; last_rc = 0; px = 0; py = 0; ph = 0;
		sample.valid = 1'b0;
		sample.left_count = '0;
		sample.right_count = '0;
		sample.left_rate = '0;
		sample.right_rate = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero gains first
		pending_samples.push_back({32'sd1000, -32'sd1000, 32'sd5, -32'sd5});
		settle();
		setup(32'h0100_0000, 1'b0, 32'h0080_0000, 32'h0100_0000, 32'h0200_0000);
		pending_samples.push_back({32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
		pending_samples.push_back({32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000});
		pending_samples.push_back({32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff});
		pending_samples.push_back({32'hffffffff, 32'h00000001, 32'h0, 32'h0});
		pending_samples.push_back({32'h0, 32'h0, 32'hffffffff, 32'h1});
		for (int i = 0; i < 8; i++)
			pending_samples.push_back({-32'sd200000 * i, 32'sd200000 * i, 32'sd0, 32'sd0});
		settle();
		setup(32'hffffffff, 1'b1, 32'hffffffff, 32'hffffffff, 32'hffffffff);
		pending_samples.push_back({32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000});
		pending_samples.push_back({32'h0, 32'h0, 32'h0, 32'h0});
		pending_samples.push_back({32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555});
		settle();

		// receiver holds off while samples pile up
		setup(32'h0040_0000, 1'b0, 32'h0080_0000, 32'h0200_0000, 32'h0300_0000);
		drive_phase(20);
		hold_off = 1;
		repeat (1500) @(posedge clk);
		hold_off = 0;
		settle();

		steady = 1;
		drive_phase(150);
		settle();
		steady = 0;

		for (int p = 0; p < 6; p++) begin
			setup($urandom, 1'($urandom), $urandom, $urandom, $urandom);
			drive_phase(80);
			settle();
			setup($urandom_range(1 << 26), 1'($urandom), $urandom_range(1 << 26),
				$urandom_range(1 << 26), $urandom_range(1 << 28));
			drive_phase(80);
			settle();
		end
		setup(32'h0, 1'b0, 32'h0, 32'h0, 32'h0);
		drive_phase(20);
		settle();

		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire
